@@ design/itoa_pkg.sv @@
`timescale 1ns / 1ps
// Package for the integer to ASCII digit converter: sizes, request and result
// types, base codes and the digit to character mapping. No dependencies.
package itoa_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int BCD_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int HEX_DIGITS  = (VALUE_WIDTH + 3) / 4;
	localparam int SR_WIDTH    = 4 * BCD_DIGITS;
	localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);

	localparam logic [4:0] BASE_BIN = 5'd2;
	localparam logic [4:0] BASE_DEC = 5'd10;
	localparam logic [4:0] BASE_HEX = 5'd16;

	typedef enum logic [1:0] {
		MODE_BIN,
		MODE_HEX,
		MODE_DEC
	} radix_mode_t;

	typedef struct packed {
		logic [4:0]  number_base;
		logic [31:0] value;
	} request_t;

	typedef struct packed {
		logic [7:0] digit_char;
		logic       last_digit;
	} result_t;

	typedef struct packed {
		logic        load;
		radix_mode_t mode;
	} emit_cmd_t;

	function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = 8'h30 + {4'h0, d};
		end else begin
			c = 8'h57 + {4'h0, d};
		end
		return c;
	endfunction

endpackage

@@ design/itoa_dabble.sv @@
`timescale 1ns / 1ps
// Bit-serial binary to BCD converter using shift-and-add-3, one input bit per cycle.
// Depends on itoa_pkg.
module itoa_dabble (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [itoa_pkg::VALUE_WIDTH-1:0] value,
	output logic                              busy,
	output logic                              done,
	output logic [itoa_pkg::SR_WIDTH-1:0]     bcd
);
	import itoa_pkg::*;

	logic [VALUE_WIDTH-1:0] bin_q;
	logic [SR_WIDTH-1:0]    bcd_q;
	logic [SR_WIDTH-1:0]    adj;
	logic [CNT_WIDTH-1:0]   cnt_q;
	logic                   active_q;
	logic                   done_q;

	always_comb begin
		adj = bcd_q;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !active_q) begin
				active_q <= 1'b1;
				cnt_q    <= CNT_WIDTH'(VALUE_WIDTH);
			end else if (active_q) begin
				cnt_q <= cnt_q - CNT_WIDTH'(1);
				if (cnt_q == CNT_WIDTH'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !active_q) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (active_q) begin
			bin_q <= bin_q << 1;
			bcd_q <= {adj[SR_WIDTH-2:0], bin_q[VALUE_WIDTH-1]};
		end
	end

	assign busy = active_q || done_q;
	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

@@ design/itoa_emit.sv @@
`timescale 1ns / 1ps
// Digit emitter: shifts out one digit per cycle, most significant first, skips
// leading zeros and flags the final digit. Depends on itoa_pkg.
module itoa_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  itoa_pkg::emit_cmd_t               cmd,
	input  logic [itoa_pkg::VALUE_WIDTH-1:0] value,
	input  logic [itoa_pkg::SR_WIDTH-1:0]     bcd,
	output logic                              busy,
	output itoa_pkg::result_t                 result,
	output logic                              result_strobe
);
	import itoa_pkg::*;

	localparam int BinShift = SR_WIDTH - VALUE_WIDTH;
	localparam int HexShift = SR_WIDTH - 4 * HEX_DIGITS;

	logic [SR_WIDTH-1:0]  sr_q;
	logic [SR_WIDTH-1:0]  ext;
	logic [CNT_WIDTH-1:0] rem_q;
	radix_mode_t          mode_q;
	logic                 active_q;
	logic                 seen_q;
	logic [3:0]           digit;
	logic                 last;
	logic                 emit;
	result_t              result_q;
	logic                 strobe_q;

	assign ext = SR_WIDTH'(value);

	always_comb begin
		if (mode_q == MODE_BIN) begin
			digit = {3'b000, sr_q[SR_WIDTH-1]};
		end else begin
			digit = sr_q[SR_WIDTH-1 -: 4];
		end
		last = (rem_q == CNT_WIDTH'(1));
		emit = active_q && (seen_q || last || (digit != 4'd0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			seen_q   <= 1'b0;
			strobe_q <= 1'b0;
			mode_q   <= MODE_BIN;
			rem_q    <= '0;
		end else begin
			strobe_q <= emit;
			if (cmd.load && !active_q) begin
				active_q <= 1'b1;
				seen_q   <= 1'b0;
				mode_q   <= cmd.mode;
				unique case (cmd.mode)
					MODE_BIN: rem_q <= CNT_WIDTH'(VALUE_WIDTH);
					MODE_HEX: rem_q <= CNT_WIDTH'(HEX_DIGITS);
					MODE_DEC: rem_q <= CNT_WIDTH'(BCD_DIGITS);
					default:  rem_q <= CNT_WIDTH'(1);
				endcase
			end else if (active_q) begin
				rem_q <= rem_q - CNT_WIDTH'(1);
				if (emit) begin
					seen_q <= 1'b1;
				end
				if (last) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !active_q) begin
			unique case (cmd.mode)
				MODE_BIN: sr_q <= ext << BinShift;
				MODE_HEX: sr_q <= ext << HexShift;
				MODE_DEC: sr_q <= bcd;
				default:  sr_q <= '0;
			endcase
		end else if (active_q) begin
			if (mode_q == MODE_BIN) begin
				sr_q <= sr_q << 1;
			end else begin
				sr_q <= sr_q << 4;
			end
		end
		if (emit) begin
			result_q.digit_char <= digit_to_ascii(digit);
			result_q.last_digit <= last;
		end
	end

	assign busy          = active_q;
	assign result        = result_q;
	assign result_strobe = strobe_q;

endmodule

@@ design/integer_to_ascii_digits.sv @@
`timescale 1ns / 1ps
// Top level of the integer to ASCII digit converter.
// Depends on itoa_pkg, itoa_dabble and itoa_emit.
//
// A request is taken at a clock edge where start is high and busy is low; it
// carries a 32-bit unsigned value and a base (2, 10 or 16; any other base is
// taken and produces nothing). Digits come out most significant first, one per
// strobe on result_strobe, with last_digit set on the final one; the receiver
// must take every digit in the cycle it is shown. Leading zero positions are
// stepped over silently, so how long a request occupies the block depends
// only on its base: the emitter steps through all 32 bits for base 2 or all
// 8 hex digits for base 16; for base 10 the bit-serial BCD converter first
// takes in the value bit by bit, then its done strobe loads the 10 BCD digits
// into the emitter. The final digit is shown in the first cycle busy is low.
module integer_to_ascii_digits (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  itoa_pkg::request_t request,
	output logic               busy,
	output itoa_pkg::result_t  result,
	output logic               result_strobe
);
	import itoa_pkg::*;

	logic                   accept;
	logic [VALUE_WIDTH-1:0] value;
	logic                   conv_start;
	logic                   conv_busy;
	logic                   conv_done;
	logic [SR_WIDTH-1:0]    bcd;
	logic                   emit_busy;
	emit_cmd_t              cmd;

	assign accept = start && !busy;
	assign value  = VALUE_WIDTH'(request.value);
	assign busy   = conv_busy || emit_busy;

	always_comb begin
		conv_start = 1'b0;
		cmd.load   = conv_done;
		cmd.mode   = MODE_DEC;
		if (accept) begin
			unique case (request.number_base)
				BASE_BIN: begin
					cmd.load = 1'b1;
					cmd.mode = MODE_BIN;
				end
				BASE_HEX: begin
					cmd.load = 1'b1;
					cmd.mode = MODE_HEX;
				end
				BASE_DEC: conv_start = 1'b1;
				default:  conv_start = 1'b0;
			endcase
		end
	end

	itoa_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.value  (value),
		.busy   (conv_busy),
		.done   (conv_done),
		.bcd    (bcd)
	);

	itoa_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.value         (value),
		.bcd           (bcd),
		.busy          (emit_busy),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule
